### design/ifd_pkg.sv
// Shared constants and types for the information frame deframer.
`timescale 1ns / 1ps

package ifd_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_FLAG    = 8'h5E;
    localparam logic [7:0] ESC_ESC     = 8'h5D;
    localparam logic [7:0] CTRL_SEQ0   = 8'h00;
    localparam logic [7:0] CTRL_SEQ1   = 8'h02;
    localparam logic [7:0] FIRST_START = 8'h01;
    localparam logic [7:0] FIRST_SHORT = 8'h00;

    localparam logic [7:0] SENDER_ADDR_RESET = 8'h03;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_CTRL  = 3'd2;
    localparam logic [2:0] PH_FIRST = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    localparam int LEN_W      = 11;
    localparam int OUT_DATA_W = 24;

    // Frame state apart from the payload byte counter
    typedef struct packed {
        logic [2:0] phase;
        logic       esc_pending;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [7:0] xor_sum;
        logic       frame_seq;
        logic       too_long;
    } frm_state_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       payload_byte;
        logic             frame_done;
        logic             frame_good;
        logic [LEN_W-1:0] frame_length;
        logic             seq_bit;
    } frm_result_t;

endpackage

### design/ifd_step.sv
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps

module ifd_step
    import ifd_pkg::*;
#(
    parameter int MAX_LEN = 1024,
    parameter int CNT_W   = 11
)
(
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       sender_address,
    input  frm_state_t       st,
    input  logic [CNT_W-1:0] cnt,
    output frm_state_t       st_next,
    output logic [CNT_W-1:0] cnt_next,
    output frm_result_t      res
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    frm_state_t fresh;

    always_comb
    begin
        fresh             = st;
        fresh.esc_pending = 1'b0;
        fresh.held_byte   = 8'h00;
        fresh.held_valid  = 1'b0;
        fresh.xor_sum     = 8'h00;
        fresh.too_long    = 1'b0;
        fresh.phase       = PH_ADDR;
    end

    always_comb
    begin
        logic       have;
        logic [7:0] dec;
        have     = 1'b0;
        dec      = rx_byte;
        st_next  = st;
        cnt_next = cnt;
        res      = '0;

        case (st.phase)
            PH_HUNT:
            begin
                if (rx_byte == FLAG_BYTE)
                begin
                    st_next  = fresh;
                    cnt_next = '0;
                end
            end
            PH_ADDR:
            begin
                if (rx_byte == sender_address)
                    st_next.phase = PH_CTRL;
                else if (rx_byte == FLAG_BYTE)
                begin
                    st_next  = fresh;
                    cnt_next = '0;
                end
                else
                    st_next.phase = PH_HUNT;
            end
            PH_CTRL:
            begin
                if (rx_byte inside {CTRL_SEQ0, CTRL_SEQ1})
                begin
                    st_next.frame_seq = rx_byte[1];
                    st_next.phase     = PH_FIRST;
                end
                else if (rx_byte == FLAG_BYTE)
                begin
                    st_next  = fresh;
                    cnt_next = '0;
                end
                else
                    st_next.phase = PH_HUNT;
            end
            PH_FIRST:
            begin
                if (rx_byte == FIRST_START)
                begin
                    st_next.held_byte  = FIRST_START;
                    st_next.held_valid = 1'b1;
                    st_next.phase      = PH_DATA;
                end
                else if (rx_byte == FIRST_SHORT)
                begin
                    // Short frame: a lone zero is a complete good frame
                    res.byte_valid   = 1'b1;
                    res.frame_done   = 1'b1;
                    res.frame_good   = 1'b1;
                    res.frame_length = LEN_W'(1);
                    st_next.phase    = PH_HUNT;
                end
                else if (rx_byte == FLAG_BYTE)
                begin
                    st_next  = fresh;
                    cnt_next = '0;
                end
                else
                    st_next.phase = PH_HUNT;
            end
            default:
            begin
                if (rx_byte == ESC_BYTE)
                    st_next.esc_pending = 1'b1;
                else if (rx_byte == FLAG_BYTE)
                begin
                    res.frame_done   = 1'b1;
                    res.frame_length = LEN_W'(cnt);
                    res.frame_good   = st.held_valid && (st.held_byte == st.xor_sum)
                                       && !st.too_long;
                    st_next.esc_pending = 1'b0;
                    st_next.phase       = PH_HUNT;
                end
                else if (st.esc_pending)
                begin
                    st_next.esc_pending = 1'b0;
                    have = 1'b1;
                    if (rx_byte == ESC_FLAG)
                        dec = FLAG_BYTE;
                    else if (rx_byte == ESC_ESC)
                        dec = ESC_BYTE;
                end
                else
                    have = 1'b1;

                if (have)
                begin
                    // Release the held byte; drop it once the frame is full
                    if (st.held_valid)
                    begin
                        if (cnt >= MAX_CNT)
                            st_next.too_long = 1'b1;
                        else
                        begin
                            res.byte_valid   = 1'b1;
                            res.payload_byte = st.held_byte;
                            st_next.xor_sum  = st.xor_sum ^ st.held_byte;
                            cnt_next         = cnt + 1'b1;
                        end
                    end
                    st_next.held_byte  = dec;
                    st_next.held_valid = 1'b1;
                end
            end
        endcase

        res.seq_bit = st_next.frame_seq;
    end

endmodule

### design/info_frame_deframer_top.sv
// Top level of the information frame deframer: state and result registers.
`timescale 1ns / 1ps

// Usage:
//   s_axis_* carries raw bytes from the serial receiver, one byte per beat.
//   m_axis_* carries exactly one result beat for every input beat: tuser marks
//   a delivered payload byte, tlast marks the beat on which a frame ended, and
//   tdata holds the byte, the good flag, the length and the sequence bit.
//   cfg_we/cfg_wdata load the expected sender address; write it only while
//   no result is pending.
// Output: a byte's result is registered to m_axis in the cycle after its input
//   beat. Throughput: one byte per cycle when not stalled, set by the single
//   output register; frame state updates in the same cycle a byte is accepted.
// Stall: while a result waits, s_axis_tready follows m_axis_tready, so a new
//   byte is taken in the same cycle the waiting result is taken.
// Reset: the block hunts for an opening flag, the sender address returns to
//   3 and no result is pending.
module info_frame_deframer_top
    import ifd_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_good,
                                                  // [19:9] frame_length, [20] seq_bit
    output logic                  m_axis_tuser,   // [0] byte_valid
    output logic                  m_axis_tlast,   // frame_done
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [7:0]       addr_reg;
    frm_state_t       st_reg;
    frm_state_t       st_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    frm_result_t      res_next;
    frm_result_t      res_reg;
    logic             out_valid_reg;
    logic             in_fire;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ifd_step #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_step (
        .rx_byte        (s_axis_tdata),
        .sender_address (addr_reg),
        .st             (st_reg),
        .cnt            (cnt_reg),
        .st_next        (st_next),
        .cnt_next       (cnt_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= SENDER_ADDR_RESET;
        else if (cfg_we)
            addr_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{phase: PH_HUNT, esc_pending: 1'b0, held_byte: 8'h00,
                               held_valid: 1'b0, xor_sum: 8'h00, frame_seq: 1'b0,
                               too_long: 1'b0};
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                st_reg        <= st_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.byte_valid;
    assign m_axis_tlast  = res_reg.frame_done;
    assign m_axis_tdata  = {3'b000, res_reg.seq_bit, res_reg.frame_length,
                            res_reg.frame_good, res_reg.payload_byte};

endmodule

### design/ifd_checker.sv
// Port-level checks for the information frame deframer, bound to the top level.
`timescale 1ns / 1ps

module ifd_checker
    import ifd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // Every accepted byte yields a result beat on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // An empty output register never stalls the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("payload bits set without a delivered byte");

    a_no_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[19:8] == 12'h000)
        else $error("frame status set without frame end");

endmodule

bind info_frame_deframer_top ifd_checker u_ifd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
